// ===== hw/rtl/key_value_packet_deframer_assert.svh =====
// Assertion helpers for the deframer.
`ifndef KEY_VALUE_PACKET_DEFRAMER_ASSERT_SVH
`define KEY_VALUE_PACKET_DEFRAMER_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define KVPD_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("kvpd assertion failed");

// Next-cycle implication, checked out of reset.
`define KVPD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("kvpd assertion failed");

`endif

// ===== hw/rtl/kvpd_pkg.sv =====
`default_nettype none
package kvpd_pkg;

    localparam int BYTE_W = 8;
    localparam int KIND_W = 3;
    localparam int CFG_IDX_W = 2;

    typedef enum logic [KIND_W-1:0] {
        KIND_NAME      = 3'd0,
        KIND_KEY       = 3'd1,
        KIND_VALUE     = 3'd2,
        KIND_KEY_END   = 3'd3,
        KIND_VALUE_END = 3'd4,
        KIND_ACCEPT    = 3'd5,
        KIND_REJECT    = 3'd6
    } t_kind;

    typedef enum logic [1:0] {
        PH_NAME   = 2'd0,
        PH_TOKENS = 2'd1,
        PH_CHECK  = 2'd2
    } t_phase;

    localparam logic [CFG_IDX_W-1:0] CFG_START      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DELIM      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TOKENS_END = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_END  = 2'd3;

    localparam logic [BYTE_W-1:0] START_RST      = 8'd58;
    localparam logic [BYTE_W-1:0] DELIM_RST      = 8'd44;
    localparam logic [BYTE_W-1:0] TOKENS_END_RST = 8'd59;
    localparam logic [BYTE_W-1:0] FRAME_END_RST  = 8'd10;

    typedef struct packed {
        logic [BYTE_W-1:0] start_marker;
        logic [BYTE_W-1:0] delimiter_marker;
        logic [BYTE_W-1:0] tokens_end_marker;
        logic [BYTE_W-1:0] frame_end_marker;
    } t_cfg;

    typedef struct packed {
        t_kind             kind;
        logic [BYTE_W-1:0] char_out;
        logic [BYTE_W-1:0] computed_sum;
    } t_res;

    typedef struct packed {
        logic              in_valid;
        t_phase            phase;
        logic              expect_key;
        logic [BYTE_W-1:0] running_sum;
    } t_stat;

endpackage
`default_nettype wire

// ===== hw/rtl/kvpd_in_if.sv =====
`default_nettype none
interface kvpd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/kvpd_res_if.sv =====
`default_nettype none
interface kvpd_res_if;
    logic       valid;
    logic       ready;
    logic [2:0] kind;
    logic [7:0] char_out;
    logic [7:0] computed_sum;

    modport source (output valid, output kind, output char_out, output computed_sum,
                    input ready);
    modport sink (input valid, input kind, input char_out, input computed_sum,
                  output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/key_value_packet_deframer.sv =====
// Key/value packet deframer.
// i_rx carries one received byte per word (valid/ready). o_res carries one tagged
// result word: kind (name/key/value char, key end, value end, accepted, rejected),
// char_out for character kinds and computed_sum for accepted/rejected.
// Marker bytes are set through i_cfg_we/i_cfg_idx/i_cfg_wdata; the user must write
// them only while idle, as the block itself does not enforce it. Bytes that produce
// no result (frame end, start marker in the name phase) are consumed silently.
// A byte taken into the input register is parsed from there and loaded into the
// result register, and its result shows on o_res from then on.
// Throughput: one byte per cycle unless a result waits on a stalled receiver;
// the parse is a compare and XOR against the held state, combinational from it.
// Reset empties both registers, puts the parser in the name phase with an empty
// checksum and restores the default markers.
// When the receiver stalls, the result register holds; the input register keeps
// taking bytes that make no result, and i_rx.ready drops once a byte with a
// result is waiting behind the held word.
`default_nettype none
module key_value_packet_deframer (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [kvpd_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [kvpd_pkg::BYTE_W-1:0]    i_cfg_wdata,
    kvpd_in_if.sink                             i_rx,
    kvpd_res_if.source                          o_res
);
    import kvpd_pkg::*;

    `include "key_value_packet_deframer_assert.svh"

    t_cfg  cfg;
    t_res  core_res;
    logic  core_valid;
    logic  buf_ready;
    t_stat stat;
    logic  res_is_char;
    logic  res_is_verdict;
    logic  check_load;

    kvpd_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_wdata(i_cfg_wdata),
        .o_cfg      (cfg)
    );

    kvpd_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rx       (i_rx),
        .i_cfg      (cfg),
        .o_res_valid(core_valid),
        .o_res      (core_res),
        .i_res_ready(buf_ready),
        .o_stat     (stat)
    );

    kvpd_out_buf u_out (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(core_valid),
        .i_res  (core_res),
        .o_ready(buf_ready),
        .o_res  (o_res)
    );

    assign res_is_char    = o_res.kind == KIND_NAME || o_res.kind == KIND_KEY ||
                            o_res.kind == KIND_VALUE;
    assign res_is_verdict = o_res.kind == KIND_ACCEPT || o_res.kind == KIND_REJECT;
    assign check_load     = core_valid && buf_ready && stat.phase == PH_CHECK;

    `KVPD_ASSERT_NOW(a_name_sum_clear, stat.phase == PH_NAME, stat.running_sum == '0)
    `KVPD_ASSERT_NOW(a_stall_has_word, !i_rx.ready, stat.in_valid && core_valid)
    `KVPD_ASSERT_NOW(a_char_no_sum, o_res.valid && res_is_char, o_res.computed_sum == '0)
    `KVPD_ASSERT_NEXT(a_check_to_name, check_load, o_res.valid && res_is_verdict)
endmodule
`default_nettype wire

// ===== hw/rtl/kvpd_cfg_regs.sv =====
`default_nettype none
module kvpd_cfg_regs (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [kvpd_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [kvpd_pkg::BYTE_W-1:0]    i_cfg_wdata,
    output kvpd_pkg::t_cfg                      o_cfg
);
    import kvpd_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_marker      <= START_RST;
            r_cfg.delimiter_marker  <= DELIM_RST;
            r_cfg.tokens_end_marker <= TOKENS_END_RST;
            r_cfg.frame_end_marker  <= FRAME_END_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_START:      r_cfg.start_marker      <= i_cfg_wdata;
                CFG_DELIM:      r_cfg.delimiter_marker  <= i_cfg_wdata;
                CFG_TOKENS_END: r_cfg.tokens_end_marker <= i_cfg_wdata;
                CFG_FRAME_END:  r_cfg.frame_end_marker  <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;
endmodule
`default_nettype wire

// ===== hw/rtl/kvpd_core.sv =====
`default_nettype none
module kvpd_core (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    kvpd_in_if.sink              i_rx,
    input  wire kvpd_pkg::t_cfg  i_cfg,
    output logic                 o_res_valid,
    output kvpd_pkg::t_res       o_res,
    input  wire logic            i_res_ready,
    output kvpd_pkg::t_stat      o_stat
);
    import kvpd_pkg::*;

    logic              r_in_valid;
    logic [BYTE_W-1:0] r_byte;
    t_phase            r_phase;
    t_phase            n_phase;
    logic              r_key;
    logic              n_key;
    logic [BYTE_W-1:0] r_sum;
    logic [BYTE_W-1:0] n_sum;
    logic              emit;
    logic              advance;
    t_res              res;

    always_comb begin
        n_phase = r_phase;
        n_key   = r_key;
        n_sum   = r_sum;
        emit    = 1'b0;
        res     = '{kind: KIND_NAME, char_out: '0, computed_sum: '0};
        if (r_byte != i_cfg.frame_end_marker) begin
            case (r_phase)
                PH_TOKENS: begin
                    emit = 1'b1;
                    if (r_byte == i_cfg.tokens_end_marker) begin
                        n_phase  = PH_CHECK;
                        res.kind = KIND_VALUE_END;
                    end else if (r_byte == i_cfg.delimiter_marker) begin
                        res.kind = r_key ? KIND_KEY_END : KIND_VALUE_END;
                        n_key    = ~r_key;
                    end else begin
                        n_sum        = r_sum ^ r_byte;
                        res.kind     = r_key ? KIND_KEY : KIND_VALUE;
                        res.char_out = r_byte;
                    end
                end
                PH_CHECK: begin
                    emit             = 1'b1;
                    res.kind         = (r_byte == r_sum) ? KIND_ACCEPT : KIND_REJECT;
                    res.computed_sum = r_sum;
                    n_phase          = PH_NAME;
                    n_key            = 1'b1;
                    n_sum            = '0;
                end
                default: begin
                    if (r_byte == i_cfg.start_marker) begin
                        n_phase = PH_TOKENS;
                        n_key   = 1'b1;
                        n_sum   = '0;
                    end else begin
                        n_phase      = PH_NAME;
                        emit         = 1'b1;
                        res.char_out = r_byte;
                    end
                end
            endcase
        end
    end

    assign advance     = r_in_valid && (!emit || i_res_ready);
    assign i_rx.ready  = !r_in_valid || advance;
    assign o_res_valid = r_in_valid && emit;
    assign o_res       = res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_phase    <= PH_NAME;
            r_key      <= 1'b1;
            r_sum      <= '0;
        end else begin
            if (advance) begin
                r_phase <= n_phase;
                r_key   <= n_key;
                r_sum   <= n_sum;
            end
            if (i_rx.ready) begin
                r_in_valid <= i_rx.valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rx.valid && i_rx.ready) begin
            r_byte <= i_rx.rx_byte;
        end
    end

    assign o_stat = '{in_valid: r_in_valid, phase: r_phase, expect_key: r_key,
                      running_sum: r_sum};
endmodule
`default_nettype wire

// ===== hw/rtl/kvpd_out_buf.sv =====
`default_nettype none
module kvpd_out_buf (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    input  wire kvpd_pkg::t_res i_res,
    output logic                o_ready,
    kvpd_res_if.source          o_res
);
    import kvpd_pkg::*;

    logic r_valid;
    t_res r_res;

    assign o_ready = !r_valid || o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_res <= i_res;
        end
    end

    assign o_res.valid        = r_valid;
    assign o_res.kind         = r_res.kind;
    assign o_res.char_out     = r_res.char_out;
    assign o_res.computed_sum = r_res.computed_sum;
endmodule
`default_nettype wire

// ===== tb/kvpd_deframe_checker.sv =====
`timescale 1ns / 100ps
module kvpd_deframe_checker
    import kvpd_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [BYTE_W-1:0]    i_cfg_wdata,
    input  wire logic                 i_rx_valid,
    input  wire logic                 i_rx_ready,
    input  wire logic [BYTE_W-1:0]    i_rx_byte,
    input  wire logic                 i_res_valid,
    input  wire logic                 i_res_ready,
    input  wire logic [KIND_W-1:0]    i_res_kind,
    input  wire logic [BYTE_W-1:0]    i_res_char,
    input  wire logic [BYTE_W-1:0]    i_res_sum,
    output int                        o_pending,
    output int                        o_errors
);

    t_cfg              markers;
    t_phase            phase_q;
    logic              expect_key;
    logic [BYTE_W-1:0] chk_sum;
    t_res              parse_events[$];
    t_res              want;
    t_res              got;
    int                mismatches = 0;

    // Returns 1 when the byte produces a result word.
    function automatic bit parse_byte(input logic [BYTE_W-1:0] b, output t_res r);
        r = '0;
        if (b == markers.frame_end_marker) begin
            return 1'b0;
        end
        case (phase_q)
            PH_TOKENS: begin
                if (b == markers.tokens_end_marker) begin
                    phase_q = PH_CHECK;
                    r.kind = KIND_VALUE_END;
                end else if (b == markers.delimiter_marker) begin
                    r.kind = expect_key ? KIND_KEY_END : KIND_VALUE_END;
                    expect_key = !expect_key;
                end else begin
                    chk_sum = chk_sum ^ b;
                    r.kind = expect_key ? KIND_KEY : KIND_VALUE;
                    r.char_out = b;
                end
                return 1'b1;
            end
            PH_CHECK: begin
                r.kind = (b == chk_sum) ? KIND_ACCEPT : KIND_REJECT;
                r.computed_sum = chk_sum;
                phase_q = PH_NAME;
                expect_key = 1'b1;
                chk_sum = '0;
                return 1'b1;
            end
            default: begin
                if (b == markers.start_marker) begin
                    phase_q = PH_TOKENS;
                    expect_key = 1'b1;
                    chk_sum = '0;
                    return 1'b0;
                end
                phase_q = PH_NAME;
                r.kind = KIND_NAME;
                r.char_out = b;
                return 1'b1;
            end
        endcase
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            markers.start_marker      = START_RST;
            markers.delimiter_marker  = DELIM_RST;
            markers.tokens_end_marker = TOKENS_END_RST;
            markers.frame_end_marker  = FRAME_END_RST;
            phase_q = PH_NAME;
            expect_key = 1'b1;
            chk_sum = '0;
            parse_events.delete();
        end else begin
            if (i_res_valid && i_res_ready) begin
                if (parse_events.size() == 0) begin
                    $display("%0t: unexpected word: kind %0d char %02h sum %02h",
                             $time, i_res_kind, i_res_char, i_res_sum);
                    mismatches++;
                end else begin
                    want = parse_events.pop_front();
                    if (i_res_kind !== want.kind || i_res_char !== want.char_out ||
                        i_res_sum !== want.computed_sum) begin
                        $display("%0t: mismatch: expected kind %0d char %02h sum %02h,",
                                 $time, want.kind, want.char_out, want.computed_sum,
                                 " got kind %0d char %02h sum %02h",
                                 i_res_kind, i_res_char, i_res_sum);
                        mismatches++;
                    end
                end
            end
            if (i_rx_valid && i_rx_ready) begin
                if (parse_byte(i_rx_byte, got)) begin
                    parse_events = {parse_events, got};
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_START:      markers.start_marker      = i_cfg_wdata;
                    CFG_DELIM:      markers.delimiter_marker  = i_cfg_wdata;
                    CFG_TOKENS_END: markers.tokens_end_marker = i_cfg_wdata;
                    CFG_FRAME_END:  markers.frame_end_marker  = i_cfg_wdata;
                    default: ;
                endcase
            end
        end
        o_pending <= parse_events.size();
        o_errors  <= mismatches;
    end

endmodule

// ===== tb/tb_key_value_packet_deframer.sv =====
`timescale 1ns / 100ps
module tb_key_value_packet_deframer;
    import kvpd_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE      = 4;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [BYTE_W-1:0]    cfg_wdata;

    kvpd_in_if  rx_if ();
    kvpd_res_if res_if ();

    int pending_events;
    int mismatches;
    int cycles = 0;
    int bytes_sent = 0;
    bit quiet = 1'b0;
    int recv_stall = 0;

    logic [BYTE_W-1:0] mk_start, mk_delim, mk_tend, mk_fend;
    logic [BYTE_W-1:0] tx_bytes[$];

    logic [BYTE_W-1:0] directed_bytes[23] = '{
        8'h00, 8'hFF, FRAME_END_RST, START_RST, 8'h00, START_RST, DELIM_RST,
        FRAME_END_RST, 8'hFF, DELIM_RST, 8'h33, 8'h08, TOKENS_END_RST, 8'h01,
        START_RST, 8'h33, 8'h08, TOKENS_END_RST, TOKENS_END_RST,
        START_RST, DELIM_RST, TOKENS_END_RST, 8'h00
    };

    key_value_packet_deframer u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_wdata (cfg_wdata),
        .i_rx        (rx_if),
        .o_res       (res_if)
    );

    kvpd_deframe_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_wdata (cfg_wdata),
        .i_rx_valid  (rx_if.valid),
        .i_rx_ready  (rx_if.ready),
        .i_rx_byte   (rx_if.rx_byte),
        .i_res_valid (res_if.valid),
        .i_res_ready (res_if.ready),
        .i_res_kind  (res_if.kind),
        .i_res_char  (res_if.char_out),
        .i_res_sum   (res_if.computed_sum),
        .o_pending   (pending_events),
        .o_errors    (mismatches)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("tb_key_value_packet_deframer: errors");
            $finish;
        end
    end

    // receiver: random stall after each accepted word
    initial begin
        res_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (!i_rst_n) begin
                res_if.ready <= 1'b0;
            end else if (recv_stall > 0) begin
                recv_stall--;
                if (recv_stall == 0) begin
                    res_if.ready <= 1'b1;
                end
            end else if (res_if.valid && res_if.ready) begin
                recv_stall = quiet ? 0 : $urandom_range(0, 11);
                if (recv_stall > 0) begin
                    res_if.ready <= 1'b0;
                end
            end else begin
                res_if.ready <= 1'b1;
            end
        end
    end

    function automatic logic [BYTE_W-1:0] pick_byte(input logic [BYTE_W-1:0] x, y, z);
        logic [BYTE_W-1:0] v;
        v = 8'($urandom_range(0, 255));
        while (v == x || v == y || v == z) begin
            v = 8'($urandom_range(0, 255));
        end
        return v;
    endfunction

    task automatic push_byte(input logic [BYTE_W-1:0] b);
        if ($urandom_range(0, 15) == 0) begin
            tx_bytes = {tx_bytes, mk_fend};
        end
        tx_bytes = {tx_bytes, b};
    endtask

    task automatic add_packet();
        logic [BYTE_W-1:0] sum;
        logic [BYTE_W-1:0] t;
        int pairs;
        bit cut;
        sum = '0;
        cut = ($urandom_range(0, 7) == 0);
        repeat ($urandom_range(0, 4)) push_byte(pick_byte(mk_start, mk_fend, mk_fend));
        push_byte(mk_start);
        pairs = $urandom_range(1, 3);
        for (int p = 0; p < pairs; p++) begin
            repeat ($urandom_range(0, 4)) begin
                t = pick_byte(mk_delim, mk_tend, mk_fend);
                sum = sum ^ t;
                push_byte(t);
            end
            push_byte(mk_delim);
            repeat ($urandom_range(0, 4)) begin
                t = pick_byte(mk_delim, mk_tend, mk_fend);
                sum = sum ^ t;
                push_byte(t);
            end
            if (p < pairs - 1) begin
                push_byte(mk_delim);
            end
        end
        if (cut) begin
            return;
        end
        push_byte(mk_tend);
        push_byte(($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255)) : sum);
    endtask

    task automatic send_byte(input logic [BYTE_W-1:0] b);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            rx_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        rx_if.valid   <= 1'b1;
        rx_if.rx_byte <= b;
        @(posedge i_clk);
        while (!rx_if.ready) @(posedge i_clk);
        if (b != mk_fend) begin
            bytes_sent++;
        end
    endtask

    task automatic send_queued();
        while (tx_bytes.size() != 0) begin
            send_byte(tx_bytes.pop_front());
        end
    endtask

    task automatic drain();
        rx_if.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_events != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BYTE_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= val;
        @(posedge i_clk);
    endtask

    task automatic write_markers(input logic [BYTE_W-1:0] s, d, t, f);
        mk_start = s;
        mk_delim = d;
        mk_tend  = t;
        mk_fend  = f;
        write_reg(CFG_START, s);
        write_reg(CFG_DELIM, d);
        write_reg(CFG_TOKENS_END, t);
        write_reg(CFG_FRAME_END, f);
        cfg_we <= 1'b0;
    endtask

    initial begin
        int budget;
        int phase_start;
        i_rst_n       <= 1'b0;
        cfg_we        <= 1'b0;
        cfg_idx       <= CFG_START;
        cfg_wdata     <= '0;
        rx_if.valid   <= 1'b0;
        rx_if.rx_byte <= '0;
        mk_start = START_RST;
        mk_delim = DELIM_RST;
        mk_tend  = TOKENS_END_RST;
        mk_fend  = FRAME_END_RST;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_bytes[i]) tx_bytes = {tx_bytes, directed_bytes[i]};
        send_queued();

        for (int ph = 0; ph < 8; ph++) begin
            if (ph > 0) begin
                drain();
                case (ph)
                    1: write_markers(8'h00, 8'hFF, 8'h01, 8'hFE);
                    2: write_markers(8'hFF, 8'h00, 8'h80, 8'h7F);
                    // start, delimiter and tokens end all equal
                    3: write_markers(8'h3C, 8'h3C, 8'h3C, 8'hA5);
                    // delimiter equals tokens end
                    4: write_markers(8'h40, 8'h21, 8'h21, 8'h0D);
                    // frame end hides the start marker
                    5: write_markers(8'h99, 8'h42, 8'h43, 8'h99);
                    default: write_markers(8'($urandom_range(0, 255)),
                                           8'($urandom_range(0, 255)),
                                           8'($urandom_range(0, 255)),
                                           8'($urandom_range(0, 255)));
                endcase
            end
            budget = (ph == 5) ? 60 : 170;
            phase_start = bytes_sent;
            while (bytes_sent - phase_start < budget) begin
                quiet = ($urandom_range(0, 4) == 0);
                if ($urandom_range(0, 7) == 0) begin
                    repeat ($urandom_range(1, 6)) push_byte(8'($urandom_range(0, 255)));
                end else begin
                    add_packet();
                end
                send_queued();
            end
        end

        quiet = 1'b0;
        drain();
        repeat (8) @(posedge i_clk);
        if (mismatches == 0 && pending_events == 0) begin
            $display("tb_key_value_packet_deframer: clean");
        end else begin
            $display("tb_key_value_packet_deframer: errors");
        end
        $finish;
    end

endmodule
